>>> src/gcc_pkg.sv
`timescale 1ns / 1ps

package gcc_pkg;

    localparam int AMP_BITS_DEF   = 16;
    localparam int STAMP_BITS_DEF = 48;

    localparam int CFG_ADDR_BITS  = 6;
    localparam int CFG_DATA_BITS  = 64;
    localparam int EXT_STAMP_BITS = 64;
    localparam int NUM_CHANNELS   = 3;

    localparam logic [63:0] CALIB_RESET    = 64'h0100_0000_0000_0000;
    localparam logic [15:0] VETO_THR_RESET = 16'd50;
    localparam logic [15:0] PROMPT_RESET   = 16'd5000;
    localparam logic [15:0] RAND_LO_RESET  = 16'd7000;
    localparam logic [15:0] RAND_HI_RESET  = 16'd12000;

    localparam logic signed [31:0] ENERGY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ENERGY_MIN = -32'sh7FFF_FFFF - 32'sh1;

    typedef enum logic [2:0] {
        REG_CALIB_FIRST  = 3'd0,
        REG_CALIB_SECOND = 3'd1,
        REG_CALIB_THIRD  = 3'd2,
        REG_VETO_THR     = 3'd3,
        REG_PROMPT       = 3'd4,
        REG_RAND_LO      = 3'd5,
        REG_RAND_HI      = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PAIR_NONE = 2'd0,
        PAIR_12   = 2'd1,
        PAIR_13   = 2'd2,
        PAIR_23   = 2'd3
    } t_pair;

    typedef enum logic [1:0] {
        WIN_NONE   = 2'd0,
        WIN_PROMPT = 2'd1,
        WIN_RANDOM = 2'd2
    } t_win;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0][63:0] calib;
        logic [15:0]                   veto_thr;
        logic [15:0]                   prompt_window;
        logic [15:0]                   random_low;
        logic [15:0]                   random_high;
    } t_cfg;

    // Stage load strobes shared by the datapath modules.
    typedef struct packed {
        logic load_s2;
        logic load_s3;
    } t_pipe_ctrl;

endpackage

>>> src/gcc_if.sv
`timescale 1ns / 1ps

interface gcc_in_if import gcc_pkg::*; #(
    parameter int AMP_BITS   = AMP_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [AMP_BITS-1:0]   amp_one;
    logic [AMP_BITS-1:0]   amp_two;
    logic [AMP_BITS-1:0]   amp_three;
    logic [15:0]           veto_one;
    logic [15:0]           veto_two;
    logic [15:0]           veto_three;
    logic [2:0]            pileup_mask;
    logic signed [15:0]    time_one;
    logic signed [15:0]    time_two;
    logic signed [15:0]    time_three;
    logic [STAMP_BITS-1:0] module_stamp;

    modport source (
        output valid, amp_one, amp_two, amp_three, veto_one, veto_two, veto_three,
               pileup_mask, time_one, time_two, time_three, module_stamp,
        input  ready
    );
    modport sink (
        input  valid, amp_one, amp_two, amp_three, veto_one, veto_two, veto_three,
               pileup_mask, time_one, time_two, time_three, module_stamp,
        output ready
    );
endinterface

interface gcc_out_if import gcc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [EXT_STAMP_BITS-1:0] extended_stamp;
    logic [2:0]                single_mask;
    logic [2:0]                suppressed_mask;
    logic signed [31:0]        energy_one;
    logic signed [31:0]        energy_two;
    logic signed [31:0]        energy_three;
    logic [1:0]                pair_code;
    logic signed [16:0]        time_difference;
    logic [1:0]                window_class;

    modport source (
        output valid, extended_stamp, single_mask, suppressed_mask, energy_one,
               energy_two, energy_three, pair_code, time_difference, window_class,
        input  ready
    );
    modport sink (
        input  valid, extended_stamp, single_mask, suppressed_mask, energy_one,
               energy_two, energy_three, pair_code, time_difference, window_class,
        output ready
    );
endinterface

>>> src/gcc_apb_regs.sv
`timescale 1ns / 1ps

module gcc_apb_regs import gcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);
    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_BITS-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_CALIB_FIRST:  n_cfg.calib[0]      = pwdata;
                REG_CALIB_SECOND: n_cfg.calib[1]      = pwdata;
                REG_CALIB_THIRD:  n_cfg.calib[2]      = pwdata;
                REG_VETO_THR:     n_cfg.veto_thr      = pwdata[15:0];
                REG_PROMPT:       n_cfg.prompt_window = pwdata[15:0];
                REG_RAND_LO:      n_cfg.random_low    = pwdata[15:0];
                REG_RAND_HI:      n_cfg.random_high   = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CALIB_FIRST:  prdata = r_cfg.calib[0];
            REG_CALIB_SECOND: prdata = r_cfg.calib[1];
            REG_CALIB_THIRD:  prdata = r_cfg.calib[2];
            REG_VETO_THR:     prdata = CFG_DATA_BITS'(r_cfg.veto_thr);
            REG_PROMPT:       prdata = CFG_DATA_BITS'(r_cfg.prompt_window);
            REG_RAND_LO:      prdata = CFG_DATA_BITS'(r_cfg.random_low);
            REG_RAND_HI:      prdata = CFG_DATA_BITS'(r_cfg.random_high);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calib[0]      <= CALIB_RESET;
            r_cfg.calib[1]      <= CALIB_RESET;
            r_cfg.calib[2]      <= CALIB_RESET;
            r_cfg.veto_thr      <= VETO_THR_RESET;
            r_cfg.prompt_window <= PROMPT_RESET;
            r_cfg.random_low    <= RAND_LO_RESET;
            r_cfg.random_high   <= RAND_HI_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> src/gcc_calib_lane.sv
`timescale 1ns / 1ps

module gcc_calib_lane import gcc_pkg::*; #(
    parameter int AMP_BITS = AMP_BITS_DEF
) (
    input  logic               i_clk,
    input  t_pipe_ctrl         i_ctrl,
    input  logic [AMP_BITS-1:0] i_amp,
    input  logic [63:0]        i_calib,
    output logic signed [31:0] o_energy
);
    localparam int PROD_BITS = AMP_BITS + 32;

    logic [PROD_BITS-1:0] r_prod;
    logic signed [31:0]   r_energy;
    logic signed [63:0]   w_sum;
    logic signed [45:0]   w_scaled;
    logic signed [31:0]   n_energy;

    // Amplitude times Q8.24 gain over four is a Q.26 value. The offset is
    // aligned to the same scale with the half-LSB rounding bit folded in,
    // so a single add followed by the shift gives round-half-up plus offset.
    assign w_sum = $signed(64'(r_prod))
                 + $signed({{14{i_calib[31]}}, i_calib[31:0], 1'b1, 17'b0});
    assign w_scaled = w_sum[63:18];

    always_comb begin
        if (w_scaled > 46'(ENERGY_MAX)) begin
            n_energy = ENERGY_MAX;
        end else if (w_scaled < 46'(ENERGY_MIN)) begin
            n_energy = ENERGY_MIN;
        end else begin
            n_energy = w_scaled[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s2) begin
            r_prod <= PROD_BITS'(i_amp) * PROD_BITS'(i_calib[63:32]);
        end
        if (i_ctrl.load_s3) begin
            r_energy <= n_energy;
        end
    end

    assign o_energy = r_energy;

endmodule

>>> src/gcc_stamp_ext.sv
`timescale 1ns / 1ps

module gcc_stamp_ext import gcc_pkg::*; #(
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pipe_ctrl                i_ctrl,
    input  logic [STAMP_BITS-1:0]     i_stamp,
    output logic [EXT_STAMP_BITS-1:0] o_ext_stamp
);
    logic [STAMP_BITS-1:0]     r_prev;
    logic [EXT_STAMP_BITS-1:0] r_offset;
    logic [EXT_STAMP_BITS-1:0] n_offset;
    logic [STAMP_BITS-1:0]     r_stamp2;
    logic [EXT_STAMP_BITS-1:0] r_offset2;
    logic [EXT_STAMP_BITS-1:0] r_ext;

    // A stamp that does not move forward is taken as a wrap or a restart.
    assign n_offset = (i_stamp > r_prev) ? r_offset
                                         : r_offset + EXT_STAMP_BITS'(r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_offset <= '0;
        end else if (i_ctrl.load_s2) begin
            r_prev   <= i_stamp;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s2) begin
            r_stamp2  <= i_stamp;
            r_offset2 <= n_offset;
        end
        if (i_ctrl.load_s3) begin
            r_ext <= r_offset2 + EXT_STAMP_BITS'(r_stamp2);
        end
    end

    assign o_ext_stamp = r_ext;

endmodule

>>> src/gamma_coincidence_classifier.sv
`timescale 1ns / 1ps

// Gamma-gamma coincidence classifier with Compton suppression. Each event
// word gives exactly one result word, in order. The datapath is three
// register stages (input, product, result), and the result word is
// presented from the result stage. A new event is taken every cycle while
// results are drained. The product stage exists because the per-channel
// calibration multiplier is registered before the rounding, offset add and
// saturation. The timestamp extension state is updated as each event leaves
// the input stage. Configuration writes go through the APB port; the user
// must make them while no event is in flight, which the block itself does
// not enforce.
module gamma_coincidence_classifier import gcc_pkg::*; #(
    parameter int AMP_BITS   = AMP_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gcc_in_if.sink                   i_evt,
    gcc_out_if.source                o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);
    t_cfg       w_cfg;
    t_pipe_ctrl w_ctrl;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_load_s1;

    // Input stage
    logic [AMP_BITS-1:0]   r_amp1  [NUM_CHANNELS];
    logic [15:0]           r_veto1 [NUM_CHANNELS];
    logic signed [15:0]    r_time1 [NUM_CHANNELS];
    logic [2:0]            r_pile1;
    logic [STAMP_BITS-1:0] r_stamp1;

    // Product stage
    logic [2:0]         n_single2, r_single2;
    logic [2:0]         n_supp2, r_supp2;
    t_pair              n_pair2, r_pair2;
    logic signed [16:0] n_dt2, r_dt2;

    // Result stage
    logic [2:0]         r_single3, r_supp3;
    t_pair              r_pair3;
    logic signed [16:0] r_dt3;
    t_win               n_win3, r_win3;
    logic [16:0]        w_abs_dt;

    logic signed [31:0]        w_energy [NUM_CHANNELS];
    logic [EXT_STAMP_BITS-1:0] w_ext_stamp;

    // Handshake: a stage may load when it is empty or the next one moves.
    assign w_rdy3         = !r_v3 || o_res.ready;
    assign w_rdy2         = !r_v2 || w_rdy3;
    assign w_rdy1         = !r_v1 || w_rdy2;
    assign i_evt.ready    = w_rdy1;
    assign w_load_s1      = i_evt.valid && w_rdy1;
    assign w_ctrl.load_s2 = r_v1 && w_rdy2;
    assign w_ctrl.load_s3 = r_v2 && w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_evt.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    gcc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_ff @(posedge i_clk) begin
        if (w_load_s1) begin
            r_amp1[0]  <= i_evt.amp_one;
            r_amp1[1]  <= i_evt.amp_two;
            r_amp1[2]  <= i_evt.amp_three;
            r_veto1[0] <= i_evt.veto_one;
            r_veto1[1] <= i_evt.veto_two;
            r_veto1[2] <= i_evt.veto_three;
            r_time1[0] <= i_evt.time_one;
            r_time1[1] <= i_evt.time_two;
            r_time1[2] <= i_evt.time_three;
            r_pile1    <= i_evt.pileup_mask;
            r_stamp1   <= i_evt.module_stamp;
        end
    end

    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_lane
        gcc_calib_lane #(
            .AMP_BITS (AMP_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_amp    (r_amp1[k]),
            .i_calib  (w_cfg.calib[k]),
            .o_energy (w_energy[k])
        );

        assign n_single2[k] = (r_amp1[k] != '0) && !r_pile1[k];
        assign n_supp2[k]   = n_single2[k] && (r_veto1[k] < w_cfg.veto_thr);
    end

    gcc_stamp_ext #(
        .STAMP_BITS (STAMP_BITS)
    ) u_stamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_stamp     (r_stamp1),
        .o_ext_stamp (w_ext_stamp)
    );

    always_comb begin
        priority if (n_single2[1:0] == 2'b11) begin
            n_pair2 = PAIR_12;
        end else if (n_single2[2] && n_single2[0]) begin
            n_pair2 = PAIR_13;
        end else if (n_single2[2:1] == 2'b11) begin
            n_pair2 = PAIR_23;
        end else begin
            n_pair2 = PAIR_NONE;
        end
    end

    always_comb begin
        unique case (n_pair2)
            PAIR_12:   n_dt2 = 17'(r_time1[0]) - 17'(r_time1[1]);
            PAIR_13:   n_dt2 = 17'(r_time1[0]) - 17'(r_time1[2]);
            PAIR_23:   n_dt2 = 17'(r_time1[1]) - 17'(r_time1[2]);
            PAIR_NONE: n_dt2 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_s2) begin
            r_single2 <= n_single2;
            r_supp2   <= n_supp2;
            r_pair2   <= n_pair2;
            r_dt2     <= n_dt2;
        end
    end

    assign w_abs_dt = r_dt2[16] ? 17'(-r_dt2) : 17'(r_dt2);

    // The prompt window wins where the two windows overlap.
    always_comb begin
        priority if (r_pair2 == PAIR_NONE) begin
            n_win3 = WIN_NONE;
        end else if (w_abs_dt < 17'(w_cfg.prompt_window)) begin
            n_win3 = WIN_PROMPT;
        end else if (w_abs_dt > 17'(w_cfg.random_low)
                  && w_abs_dt < 17'(w_cfg.random_high)) begin
            n_win3 = WIN_RANDOM;
        end else begin
            n_win3 = WIN_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_s3) begin
            r_single3 <= r_single2;
            r_supp3   <= r_supp2;
            r_pair3   <= r_pair2;
            r_dt3     <= r_dt2;
            r_win3    <= n_win3;
        end
    end

    assign o_res.valid           = r_v3;
    assign o_res.extended_stamp  = w_ext_stamp;
    assign o_res.single_mask     = r_single3;
    assign o_res.suppressed_mask = r_supp3;
    assign o_res.energy_one      = w_energy[0];
    assign o_res.energy_two      = w_energy[1];
    assign o_res.energy_three    = w_energy[2];
    assign o_res.pair_code       = r_pair3;
    assign o_res.time_difference = r_dt3;
    assign o_res.window_class    = r_win3;

`ifndef NO_ASSERTIONS
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rdy1 |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked while a pipeline stage is empty");

    a_supp_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_supp3 & ~r_single3) == 3'b000))
        else $error("suppressed channel that is not an accepted single");

    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_pair3 == PAIR_NONE) |-> (r_win3 == WIN_NONE && r_dt3 == '0))
        else $error("class or time difference given without a pair");

    a_pair_singles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_pair3 != PAIR_NONE) |-> ($countones(r_single3) >= 2))
        else $error("pair reported with fewer than two singles");

    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_single3[1:0] == 2'b11) |-> (r_pair3 == PAIR_12))
        else $error("pair priority not honored");
`endif

endmodule

>>> verif/gamma_coincidence_classifier_checker.sv
`timescale 1ns / 1ps

module gamma_coincidence_classifier_checker import gcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gcc_in_if                        i_evt,
    gcc_out_if                       i_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [63:0]        stamp;
        logic [2:0]         singles;
        logic [2:0]         suppressed;
        logic signed [31:0] energy_one;
        logic signed [31:0] energy_two;
        logic signed [31:0] energy_three;
        t_pair              pair;
        logic signed [16:0] dt;
        t_win               win;
    } t_event_result;

    t_cfg                 cfg;
    logic [63:0]          wrap_offset;
    logic [47:0]          last_stamp;
    t_event_result        expected_q[$];
    t_event_result        want;
    logic [CFG_ADDR_BITS-1:0] reg_index;

    function automatic logic signed [31:0] calibrated_energy(logic [15:0] amp,
                                                             logic [63:0] word);
        logic [47:0]        product;
        logic [48:0]        rounded;
        logic signed [31:0] offset;
        longint             sum;
        // The gain is Q8.24 and the amplitude is divided by four, so the
        // product carries 26 fraction bits; round half up down to eight.
        product = amp * word[63:32];
        rounded = product + 49'h2_0000;
        offset  = word[31:0];
        sum     = longint'(rounded >> 18) + offset;
        if (sum > ENERGY_MAX) return ENERGY_MAX;
        if (sum < ENERGY_MIN) return ENERGY_MIN;
        return 32'(sum);
    endfunction

    // Works out the result word of the event on the input channel and
    // advances the timestamp extension state.
    function automatic t_event_result predicted_result();
        logic [15:0]        amp [3];
        logic [15:0]        veto [3];
        logic signed [15:0] hit [3];
        t_event_result      r;
        int                 a;
        int                 b;
        int                 diff;
        int                 mag;
        amp[0]  = i_evt.amp_one;
        amp[1]  = i_evt.amp_two;
        amp[2]  = i_evt.amp_three;
        veto[0] = i_evt.veto_one;
        veto[1] = i_evt.veto_two;
        veto[2] = i_evt.veto_three;
        hit[0]  = i_evt.time_one;
        hit[1]  = i_evt.time_two;
        hit[2]  = i_evt.time_three;
        r = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (amp[k] != 0 && !i_evt.pileup_mask[k]) begin
                r.singles[k] = 1'b1;
                if (veto[k] < cfg.veto_thr) r.suppressed[k] = 1'b1;
            end
        end
        // A stamp that does not move forward means the module counter
        // restarted, so everything seen so far is folded into the offset.
        if (!(i_evt.module_stamp > last_stamp)) wrap_offset += last_stamp;
        last_stamp = i_evt.module_stamp;
        r.stamp = wrap_offset + i_evt.module_stamp;
        r.energy_one   = calibrated_energy(amp[0], cfg.calib[0]);
        r.energy_two   = calibrated_energy(amp[1], cfg.calib[1]);
        r.energy_three = calibrated_energy(amp[2], cfg.calib[2]);
        r.pair = PAIR_NONE;
        r.win  = WIN_NONE;
        a = 0;
        b = 1;
        if (r.singles[0] && r.singles[1]) begin
            r.pair = PAIR_12;
        end else if (r.singles[0] && r.singles[2]) begin
            r.pair = PAIR_13;
            b = 2;
        end else if (r.singles[1] && r.singles[2]) begin
            r.pair = PAIR_23;
            a = 1;
            b = 2;
        end
        if (r.pair != PAIR_NONE) begin
            diff = int'(hit[a]) - int'(hit[b]);
            mag  = diff < 0 ? -diff : diff;
            r.dt = 17'(diff);
            if (mag < int'(cfg.prompt_window)) begin
                r.win = WIN_PROMPT;
            end else if (mag > int'(cfg.random_low) && mag < int'(cfg.random_high)) begin
                r.win = WIN_RANDOM;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (exp_val !== got_val) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: %s mismatch: expected %h, got %h",
                         $realtime, field, exp_val, got_val);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.calib[0]      = CALIB_RESET;
            cfg.calib[1]      = CALIB_RESET;
            cfg.calib[2]      = CALIB_RESET;
            cfg.veto_thr      = VETO_THR_RESET;
            cfg.prompt_window = PROMPT_RESET;
            cfg.random_low    = RAND_LO_RESET;
            cfg.random_high   = RAND_HI_RESET;
            wrap_offset       = '0;
            last_stamp        = '0;
            expected_q.delete();
            o_fail_count      = 0;
            o_pending         = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_index = paddr >> 3;
                case (reg_index)
                    REG_CALIB_FIRST:  cfg.calib[0]      = pwdata;
                    REG_CALIB_SECOND: cfg.calib[1]      = pwdata;
                    REG_CALIB_THIRD:  cfg.calib[2]      = pwdata;
                    REG_VETO_THR:     cfg.veto_thr      = pwdata[15:0];
                    REG_PROMPT:       cfg.prompt_window = pwdata[15:0];
                    REG_RAND_LO:      cfg.random_low    = pwdata[15:0];
                    REG_RAND_HI:      cfg.random_high   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_evt.valid && i_evt.ready) expected_q.push_back(predicted_result());
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result word with no event outstanding, stamp %h",
                                 $realtime, i_res.extended_stamp);
                    end
                end else begin
                    want = expected_q.pop_front();
                    check_field("extended_stamp", want.stamp, i_res.extended_stamp);
                    check_field("single_mask", 64'(want.singles), 64'(i_res.single_mask));
                    check_field("suppressed_mask", 64'(want.suppressed),
                                64'(i_res.suppressed_mask));
                    check_field("energy_one", 64'(want.energy_one), 64'(i_res.energy_one));
                    check_field("energy_two", 64'(want.energy_two), 64'(i_res.energy_two));
                    check_field("energy_three", 64'(want.energy_three),
                                64'(i_res.energy_three));
                    check_field("pair_code", 64'(want.pair), 64'(i_res.pair_code));
                    check_field("time_difference", 64'(want.dt),
                                64'(i_res.time_difference));
                    check_field("window_class", 64'(want.win), 64'(i_res.window_class));
                end
            end
            o_pending = expected_q.size();
        end
    end

endmodule

>>> verif/gamma_coincidence_classifier_tb.sv
`timescale 1ns / 1ps

module gamma_coincidence_classifier_tb;
    import gcc_pkg::*;

    // Register index past the end of the map; writes to it must be dropped.
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending;

    logic [15:0] cur_thr;
    logic [15:0] cur_pw;
    logic [15:0] cur_rl;
    logic [15:0] cur_rh;
    logic [47:0] stamp_now;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_req;
    int          tx_pattern [6] = '{25, 0, 40, 10, 50, 0};
    int          rx_pattern [6] = '{0, 30, 40, 60, 15, 0};

    gcc_in_if  evt_if ();
    gcc_out_if res_if ();

    gamma_coincidence_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gamma_coincidence_classifier_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                res_if.ready = 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_BITS'(idx) << 3;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_settings(input logic [63:0] c1, input logic [63:0] c2,
                                 input logic [63:0] c3, input logic [15:0] thr,
                                 input logic [15:0] pw, input logic [15:0] rl,
                                 input logic [15:0] rh);
        cfg_write(REG_CALIB_FIRST, c1);
        cfg_write(REG_CALIB_SECOND, c2);
        cfg_write(REG_CALIB_THIRD, c3);
        cfg_write(REG_VETO_THR, 64'(thr));
        cfg_write(REG_PROMPT, 64'(pw));
        cfg_write(REG_RAND_LO, 64'(rl));
        cfg_write(REG_RAND_HI, 64'(rh));
        cur_thr = thr;
        cur_pw  = pw;
        cur_rl  = rl;
        cur_rh  = rh;
    endtask

    task automatic send_event(input logic [15:0] a1, input logic [15:0] a2,
                              input logic [15:0] a3, input logic [15:0] v1,
                              input logic [15:0] v2, input logic [15:0] v3,
                              input logic [2:0] pileup, input logic signed [15:0] t1,
                              input logic signed [15:0] t2, input logic signed [15:0] t3,
                              input logic [47:0] stamp);
        int gap;
        @(negedge i_clk);
        evt_if.valid        = 1'b1;
        evt_if.amp_one      = a1;
        evt_if.amp_two      = a2;
        evt_if.amp_three    = a3;
        evt_if.veto_one     = v1;
        evt_if.veto_two     = v2;
        evt_if.veto_three   = v3;
        evt_if.pileup_mask  = pileup;
        evt_if.time_one     = t1;
        evt_if.time_two     = t2;
        evt_if.time_three   = t3;
        evt_if.module_stamp = stamp;
        stamp_now = stamp;
        do @(posedge i_clk); while (!evt_if.ready);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            evt_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Lets every outstanding word come back before the settings change.
    task automatic drain();
        @(negedge i_clk);
        evt_if.valid = 1'b0;
        wait (pending == 0);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_amp();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_veto();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return cur_thr - 16'd1;
            2:       return cur_thr;
            default: return 16'($urandom_range(0, 100));
        endcase
    endfunction

    // Spacing between two channel times, aimed at the window edges.
    function automatic int pick_delta();
        int d;
        case ($urandom_range(0, 9))
            0:       d = int'(cur_pw) - 1;
            1:       d = int'(cur_pw);
            2:       d = int'(cur_rl);
            3:       d = int'(cur_rl) + 1;
            4:       d = int'(cur_rh) - 1;
            5:       d = int'(cur_rh);
            6, 7:    d = $urandom_range(0, 15000);
            default: d = $urandom_range(0, 65535);
        endcase
        return $urandom_range(0, 1) ? -d : d;
    endfunction

    function automatic logic [63:0] random_calib();
        logic [31:0] gain;
        logic [31:0] offset;
        case ($urandom_range(0, 2))
            0:       gain = 32'h0100_0000;
            1:       gain = $urandom_range(32'h0080_0000, 32'h0400_0000);
            default: gain = $urandom;
        endcase
        if ($urandom_range(0, 1)) offset = 32'($urandom_range(0, 8000)) - 32'd4000;
        else offset = $urandom;
        return {gain, offset};
    endfunction

    task automatic run_random(input int count, input bit with_pressure);
        logic signed [15:0] t1;
        logic [47:0]        stamp;
        logic [2:0]         pileup;
        for (int i = 0; i < count; i++) begin
            if (with_pressure && i == 100) rx_hold_req = 400;
            t1 = 16'($urandom);
            case ($urandom_range(0, 99))
                0, 1, 2, 3: stamp = stamp_now;
                4, 5, 6:    stamp = 48'($urandom_range(0, 500));
                7, 8, 9:    stamp = 48'({$urandom, $urandom});
                default:    stamp = stamp_now + 48'($urandom_range(1, 1000));
            endcase
            pileup = $urandom_range(0, 1) ? 3'b000 : 3'($urandom);
            send_event(pick_amp(), pick_amp(), pick_amp(),
                       pick_veto(), pick_veto(), pick_veto(), pileup,
                       t1, 16'(int'(t1) + pick_delta()), 16'(int'(t1) + pick_delta()),
                       stamp);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        evt_if.valid        = 1'b0;
        evt_if.amp_one      = '0;
        evt_if.amp_two      = '0;
        evt_if.amp_three    = '0;
        evt_if.veto_one     = '0;
        evt_if.veto_two     = '0;
        evt_if.veto_three   = '0;
        evt_if.pileup_mask  = '0;
        evt_if.time_one     = '0;
        evt_if.time_two     = '0;
        evt_if.time_three   = '0;
        evt_if.module_stamp = '0;
        cur_thr     = VETO_THR_RESET;
        cur_pw      = PROMPT_RESET;
        cur_rl      = RAND_LO_RESET;
        cur_rh      = RAND_HI_RESET;
        stamp_now   = '0;
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        rx_hold_req = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings after reset: window edges, pair priority, pileup, and
        // timestamp restarts.
        send_event(0, 0, 0, 0, 0, 0, 3'b000, 0, 0, 0, 48'd0);
        send_event(16'hFFFF, 16'hFFFF, 16'hFFFF, 49, 50, 16'hFFFF, 3'b000,
                   32767, -32768, 0, 48'd100);
        send_event(1, 1, 1, 0, 0, 0, 3'b001, 100, 0, -4899, 48'd200);
        send_event(10, 20, 30, 60, 40, 10, 3'b010, 0, 77, -5000, 48'd300);
        send_event(5, 6, 7, 0, 0, 0, 3'b000, -7000, 0, 0, 48'd400);
        send_event(5, 6, 7, 0, 0, 0, 3'b000, 7001, 0, 0, 48'd500);
        send_event(5, 6, 7, 0, 0, 0, 3'b000, 0, 11999, 0, 48'd600);
        send_event(5, 6, 7, 0, 0, 0, 3'b000, 12000, 0, 0, 48'd700);
        send_event(5, 6, 7, 0, 0, 0, 3'b000, 4999, 0, 0, 48'd800);
        send_event(3, 3, 3, 0, 0, 0, 3'b000, -32768, -32768, -32768, 48'd900);
        send_event(100, 200, 300, 0, 0, 0, 3'b111, 1, 2, 3, 48'd1000);
        send_event(0, 5, 0, 0, 0, 0, 3'b000, 1, 2, 3, 48'd1100);
        send_event(7, 8, 9, 0, 0, 0, 3'b000, 1, 2, 3, 48'd50);
        send_event(7, 8, 9, 0, 0, 0, 3'b000, 1, 2, 3, 48'd50);
        send_event(7, 8, 9, 0, 0, 0, 3'b000, 1, 2, 3, 48'hFFFF_FFFF_FFFF);
        send_event(7, 8, 9, 0, 0, 0, 3'b000, 1, 2, 3, 48'd0);
        send_event(7, 8, 9, 0, 0, 0, 3'b000, 1, 2, 3, 48'd1);
        drain();

        // A write past the register map must leave every setting alone.
        cfg_write(REG_SPARE, '1);
        send_event(400, 0, 401, 49, 0, 50, 3'b000, 0, 0, 9000, 48'd2);
        send_event(0, 402, 403, 0, 0, 0, 3'b000, 0, -6000, 1000, 48'd3);
        drain();

        // Extreme gains and offsets, a threshold that suppresses nearly all,
        // and both windows empty.
        load_settings({32'hFFFF_FFFF, 32'h7FFF_FFFF}, {32'h0, 32'h8000_0000},
                      {32'hFFFF_FFFF, 32'h8000_0000}, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_event(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 0, 16'hFFFF, 3'b000,
                   0, 0, 0, 48'd10);
        send_event(1, 16'hFFFF, 2, 0, 0, 0, 3'b000, 30000, 0, 0, 48'd20);
        drain();

        // Zero calibration, no suppression, windows overlapping everywhere.
        load_settings(64'd0, 64'd0, 64'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_event(9, 9, 9, 0, 0, 0, 3'b000, 3000, 0, 0, 48'd30);
        send_event(9, 9, 9, 0, 0, 0, 3'b000, 32767, -32768, 0, 48'd40);
        send_event(9, 9, 9, 0, 0, 0, 3'b100, 5, 5, 5, 48'd50);
        drain();

        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = tx_pattern[p];
            rx_idle_pct = rx_pattern[p];
            if (p == 5) begin
                load_settings(CALIB_RESET, CALIB_RESET, CALIB_RESET, VETO_THR_RESET,
                              PROMPT_RESET, RAND_LO_RESET, RAND_HI_RESET);
            end else if ($urandom_range(0, 1)) begin
                load_settings(random_calib(), random_calib(), random_calib(),
                              16'($urandom_range(0, 200)), 16'($urandom_range(0, 9000)),
                              16'($urandom_range(2000, 12000)),
                              16'($urandom_range(8000, 25000)));
            end else begin
                load_settings(random_calib(), random_calib(), random_calib(),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            run_random(310, p == 2);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/gcc_pkg.sv
src/gcc_if.sv
src/gcc_apb_regs.sv
src/gcc_calib_lane.sv
src/gcc_stamp_ext.sv
src/gamma_coincidence_classifier.sv
verif/gamma_coincidence_classifier_checker.sv
verif/gamma_coincidence_classifier_tb.sv
